// File: sv/apdu_command_parser_top_defines.svh
// assertion macros shared by the parser rtl
`ifndef APDU_COMMAND_PARSER_TOP_DEFINES_SVH
`define APDU_COMMAND_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define APCP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("apdu parser check failed");

// next-cycle implication, checked outside reset
`define APCP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("apdu parser check failed");

`endif

// File: sv/apcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apcp_pkg;

   // one byte of the command stream
   typedef struct packed {
      logic [7:0] apdu_byte;
      logic       end_of_apdu;
   } req_type;

   // one result: data byte or end-of-command summary
   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [7:0]  class_byte;
      logic [7:0]  instr_byte;
      logic [7:0]  param_one;
      logic [7:0]  param_two;
      logic [15:0] cmd_data_len;
      logic [16:0] max_rsp_len;
      logic [1:0]  status;
      logic        is_last;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_FIRST,
      PH_EXTLEN,
      PH_DATA,
      PH_TRAILER,
      PH_ERROR
   } phase_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_SHORT  = 2'd1;
   localparam logic [1:0] ST_BADLEN = 2'd2;

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Ne values for a zero Le byte
   localparam logic [16:0] NE_SHORT_ZERO = 17'd256;
   localparam logic [16:0] NE_EXT_ZERO   = 17'd65536;

   localparam logic [1:0] TRAILER_MAX = 2'd3;

   // result queue: room for two results from one request plus slack
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// File: sv/apdu_command_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming command APDU parser.
// Request channel (req_valid / req_ready / req_payload): one APDU byte per
// request, with end_of_apdu set on the final byte of a command.
// Response channel (rsp_valid / rsp_ready / rsp_payload): kind 0 carries a
// command data byte, kind 1 the end-of-command summary (CLA, INS, P1, P2,
// Nc, Ne and status). is_last marks the final response caused by a request.
// A request is parsed in the cycle it is accepted and its responses are
// written into a four-entry response queue; the first one is offered on
// rsp_valid in the next cycle if the queue was empty. One request per
// cycle is taken while the queue holds at most two entries, so the
// sustained rate is one byte per cycle; the last data byte with end
// mark yields two responses, drained one per cycle while rsp_ready is high.
// A stalled receiver fills the queue; req_ready drops when fewer than two
// entries are free and rises again as responses are taken.
// Synchronous reset empties the queue and returns the parser to the header
// phase with all length and header state cleared; the state also returns
// there after every summary.
module apdu_command_parser_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire apcp_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output apcp_pkg::rsp_type   rsp_payload
);
   import apcp_pkg::*;

   `include "apdu_command_parser_top_defines.svh"

   // parser state
   phase_type        phase_ff, phase_in;
   logic [1:0]       pos_ff, pos_in;
   logic [3:0][7:0]  hdr_ff, hdr_in;
   logic             lc_ext_ff, lc_ext_in;
   logic [15:0]      dcount_ff, dcount_in;
   logic [15:0]      remain_ff, remain_in;
   logic [15:0]      tbytes_ff, tbytes_in;
   logic [1:0]       tcount_ff, tcount_in;

   // response queue
   rsp_type                  queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]      count_ff, count_in;

   logic        req_fire, rsp_fire;
   logic        fin, emit_data;
   logic [15:0] nc;
   logic [16:0] ne;
   logic [1:0]  st;
   logic [15:0] tb_shift;
   logic [1:0]  tc_step;
   logic [1:0]  want;
   logic [7:0]  b;
   logic        e;
   logic [1:0]  push_n;
   rsp_type     data_res, sum_res, res0, res1;

   assign b        = req_payload.apdu_byte;
   assign e        = req_payload.end_of_apdu;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // accept while two free entries remain
   assign req_ready   = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   // per-byte parse: next state and the summary fields
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      lc_ext_in = lc_ext_ff;
      dcount_in = dcount_ff;
      remain_in = remain_ff;
      tbytes_in = tbytes_ff;
      tcount_in = tcount_ff;
      fin       = 1'b0;
      emit_data = 1'b0;
      nc        = '0;
      ne        = '0;
      st        = ST_OK;
      tb_shift  = {tbytes_ff[7:0], b};
      tc_step   = (tcount_ff == TRAILER_MAX) ? TRAILER_MAX : tcount_ff + 2'd1;
      want      = lc_ext_ff ? 2'd2 : 2'd1;

      unique case (phase_ff)
         PH_HEADER: begin
            hdr_in[2'd3 - pos_ff] = b;
            pos_in = pos_ff + 2'd1;
            if (pos_ff == 2'd3) begin
               phase_in = PH_FIRST;
            end
            if (e) begin
               fin = 1'b1;
               st  = (pos_ff != 2'd3) ? ST_SHORT : ST_OK;
            end
         end
         PH_FIRST: begin
            if (e) begin
               fin = 1'b1;
               ne  = (b != 8'h00) ? {9'd0, b} : NE_SHORT_ZERO;
            end else if (b == 8'h00) begin
               phase_in  = PH_EXTLEN;
               tbytes_in = '0;
               tcount_in = '0;
            end else begin
               lc_ext_in = 1'b0;
               remain_in = {8'd0, b};
               phase_in  = PH_DATA;
            end
         end
         PH_EXTLEN: begin
            tbytes_in = tb_shift;
            tcount_in = tcount_ff + 2'd1;
            if (tcount_ff == 2'd0) begin
               if (e) begin
                  fin = 1'b1;
                  st  = ST_BADLEN;
               end
            end else if (e) begin
               fin = 1'b1;
               ne  = (tb_shift != 16'd0) ? {1'b0, tb_shift} : NE_EXT_ZERO;
            end else begin
               lc_ext_in = 1'b1;
               remain_in = tb_shift;
               tbytes_in = '0;
               tcount_in = '0;
               phase_in  = (tb_shift == 16'd0) ? PH_ERROR : PH_DATA;
            end
         end
         PH_DATA: begin
            emit_data = 1'b1;
            dcount_in = dcount_ff + 16'd1;
            remain_in = remain_ff - 16'd1;
            if (remain_ff == 16'd1) begin
               phase_in  = PH_TRAILER;
               tbytes_in = '0;
               tcount_in = '0;
               if (e) begin
                  fin = 1'b1;
                  nc  = dcount_ff + 16'd1;
               end
            end else if (e) begin
               fin = 1'b1;
               nc  = dcount_ff + 16'd1;
               st  = ST_BADLEN;
            end
         end
         PH_TRAILER: begin
            tbytes_in = tb_shift;
            tcount_in = tc_step;
            nc        = dcount_ff;
            if (tc_step > want) begin
               if (e) begin
                  fin = 1'b1;
                  st  = ST_BADLEN;
               end else begin
                  phase_in = PH_ERROR;
               end
            end else if (e) begin
               fin = 1'b1;
               if (tc_step == want) begin
                  if (!lc_ext_ff) begin
                     ne = (b != 8'h00) ? {9'd0, b} : NE_SHORT_ZERO;
                  end else begin
                     ne = (tb_shift != 16'd0) ? {1'b0, tb_shift} : NE_EXT_ZERO;
                  end
               end else begin
                  st = ST_BADLEN;
               end
            end
         end
         default: begin
            phase_in = PH_ERROR;
            if (e) begin
               fin = 1'b1;
               nc  = dcount_ff;
               st  = ST_BADLEN;
            end
         end
      endcase

      // error statuses drop Ne; a short header also drops Nc
      if (st != ST_OK) begin
         ne = '0;
      end
      if (st == ST_SHORT) begin
         nc = '0;
      end

      // a summary returns the parser to its reset state
      if (fin) begin
         phase_in  = PH_HEADER;
         pos_in    = '0;
         hdr_in    = '0;
         lc_ext_in = 1'b0;
         dcount_in = '0;
         remain_in = '0;
         tbytes_in = '0;
         tcount_in = '0;
      end
   end

   // build the responses of this request
   always_comb begin
      data_res           = '0;
      data_res.kind      = KIND_DATA;
      data_res.data_byte = b;
      data_res.is_last   = !fin;

      sum_res              = '0;
      sum_res.kind         = KIND_SUMMARY;
      sum_res.class_byte   = hdr_ff[3];
      sum_res.instr_byte   = hdr_ff[2];
      sum_res.param_one    = hdr_ff[1];
      sum_res.param_two    = hdr_ff[0];
      if (phase_ff == PH_HEADER) begin
         unique case (pos_ff)
            2'd0: sum_res.class_byte = b;
            2'd1: sum_res.instr_byte = b;
            2'd2: sum_res.param_one  = b;
            default: sum_res.param_two = b;
         endcase
      end
      sum_res.cmd_data_len = nc;
      sum_res.max_rsp_len  = ne;
      sum_res.status       = st;
      sum_res.is_last      = 1'b1;

      res0   = emit_data ? data_res : sum_res;
      res1   = sum_res;
      push_n = req_fire ? ({1'b0, emit_data} + {1'b0, fin}) : 2'd0;
   end

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push_n);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(rsp_fire);
      count_in  = count_ff + QUEUE_CW'(push_n) - QUEUE_CW'(rsp_fire);
   end

   // control and parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         hdr_ff    <= '0;
         lc_ext_ff <= 1'b0;
         dcount_ff <= '0;
         remain_ff <= '0;
         tbytes_ff <= '0;
         tcount_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_fire) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            hdr_ff    <= hdr_in;
            lc_ext_ff <= lc_ext_in;
            dcount_ff <= dcount_in;
            remain_ff <= remain_in;
            tbytes_ff <= tbytes_in;
            tcount_ff <= tcount_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + QUEUE_AW'(1)] <= res1;
      end
   end

   // checks
   `APCP_ASSERT_NOW(a_queue_bound, 1'b1, count_ff <= QUEUE_CW'(QUEUE_DEPTH))
   `APCP_ASSERT_NEXT(a_summary_clears, req_fire && fin,
      phase_ff == PH_HEADER && pos_ff == 2'd0 && dcount_ff == 16'd0)
   `APCP_ASSERT_NOW(a_error_no_data, req_fire && phase_ff == PH_ERROR, !emit_data)
   `APCP_ASSERT_NEXT(a_push_visible, req_fire && fin, rsp_valid)

endmodule

`default_nettype wire
